[design/met_pkg.sv]
package met_pkg;

	// field widths
	localparam int COORD_W = 10;
	localparam int INDEX_W = 19;
	localparam int COUNT_W = 8;
	localparam int BLUE_W  = 8;
	localparam int Q_W     = 32;
	localparam int FRAC_W  = 28;

	// config port
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_MAX = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_MIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_MAX = 4'd3;

	localparam logic [Q_W-1:0] REAL_MIN_RST = 32'hE000_0000; // -2.0
	localparam logic [Q_W-1:0] REAL_MAX_RST = 32'h1000_0000; //  1.0
	localparam logic [Q_W-1:0] IMAG_MIN_RST = 32'hE800_0000; // -1.5
	localparam logic [Q_W-1:0] IMAG_MAX_RST = 32'h1800_0000; //  1.5

	// coordinate * delta: 11b signed x 33b signed, magnitude below 2^42
	localparam int PROD_W = 44;
	localparam int MAG_W  = 42;

	// divide by size-1: reciprocal multiply, one 32x32 partial product a cycle
	localparam int DIV_STEPS = 4;

	// |z|^2 escape bound, 4.0 in Q8.56
	localparam logic [63:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

	localparam logic [15:0] BLUE_BASE = 16'd20;
	localparam logic [15:0] BLUE_STEP = 16'd5;
	localparam logic [15:0] CH_MAX    = 16'd255;

	typedef struct packed {
		logic capture;    // latch coordinates
		logic z_clear;    // z = 0, iteration count = 0
		logic div_load;   // load divider with coord*delta
		logic div_axis;   // 0 real, 1 imaginary
		logic div_step;   // accumulate one partial product
		logic c_store_re;
		logic c_store_im;
		logic mul;        // register zr*zr, zi*zi, zr*zi
		logic update;     // new z from products
		logic out_load;   // fill output register
	} met_cmd_t;

	typedef struct packed {
		logic mag_over;   // |z|^2 > 4 on current products
		logic iter_max;   // iteration limit reached
	} met_sts_t;

endpackage

[design/met_if.sv]
interface met_pix_in_if;
	import met_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	modport source (output valid, column, row, input ready);
	modport sink   (input valid, column, row, output ready);
endinterface

interface met_pix_out_if;
	import met_pkg::*;
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] pixel_index;
	logic [COUNT_W-1:0] escape_count;
	logic               in_set;
	logic [BLUE_W-1:0]  blue_value;
	modport source (output valid, pixel_index, escape_count, in_set, blue_value, input ready);
	modport sink   (input valid, pixel_index, escape_count, in_set, blue_value, output ready);
endinterface

interface met_cfg_if;
	import met_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [Q_W-1:0]       data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[design/met_ctrl.sv]
module met_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  met_pkg::met_sts_t  sts,
	output met_pkg::met_cmd_t  cmd
);
	import met_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_RE,
		S_DIV_RE,
		S_LOAD_IM,
		S_DIV_IM,
		S_MUL,
		S_EVAL,
		S_FIN
	} state_t;

	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:    cmd.capture = in_valid;
			S_LOAD_RE: begin
				cmd.z_clear  = 1'b1;
				cmd.div_load = 1'b1;
				cmd.div_axis = 1'b0;
			end
			S_DIV_RE:  cmd.div_step = 1'b1;
			S_LOAD_IM: begin
				cmd.c_store_re = 1'b1;
				cmd.div_load   = 1'b1;
				cmd.div_axis   = 1'b1;
			end
			S_DIV_IM:  cmd.div_step = 1'b1;
			S_MUL: begin
				// divider holds the imaginary quotient throughout, re-latch is harmless
				cmd.c_store_im = 1'b1;
				cmd.mul        = 1'b1;
			end
			S_EVAL:    cmd.update = !sts.mag_over && !sts.iter_max;
			S_FIN:     cmd.out_load = !out_valid_q || out_ready;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_LOAD_RE;
				end
				S_LOAD_RE: begin
					step_q  <= '0;
					state_q <= S_DIV_RE;
				end
				S_DIV_RE: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST)
						state_q <= S_LOAD_IM;
				end
				S_LOAD_IM: begin
					step_q  <= '0;
					state_q <= S_DIV_IM;
				end
				S_DIV_IM: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST)
						state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_EVAL;
				S_EVAL: begin
					if (sts.mag_over || sts.iter_max)
						state_q <= S_FIN;
					else
						state_q <= S_MUL;
				end
				S_FIN: begin
					if (cmd.out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_capture_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_LOAD_RE) && !in_ready)
		else $error("capture did not start mapping");

	a_div_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD_IM) |-> ($past(state_q) == S_DIV_RE) && ($past(step_q) == STEP_LAST))
		else $error("real divide cut short");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !out_ready) |=> (state_q == S_FIN))
		else $error("finished result left while output full");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q && (state_q == S_IDLE))
		else $error("output load lost");
`endif

endmodule

[design/met_dp.sv]
module met_dp #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 640,
	parameter int MAX_ITER     = 255
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  met_pkg::met_cmd_t                 cmd,
	output met_pkg::met_sts_t                 sts,
	input  logic                              cfg_we,
	input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [met_pkg::Q_W-1:0]           cfg_data,
	input  logic [met_pkg::COORD_W-1:0]       in_column,
	input  logic [met_pkg::COORD_W-1:0]       in_row,
	output logic [met_pkg::INDEX_W-1:0]       pixel_index,
	output logic [met_pkg::COUNT_W-1:0]       escape_count,
	output logic                              in_set,
	output logic [met_pkg::BLUE_W-1:0]        blue_value
);
	import met_pkg::*;

	// floor(x/d) == (x * ceil(2^54/d)) >> 54 for x < 2^42 and d < 2^12
	localparam int RECIP_SH = MAG_W + 12;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int ACC_W    = MAG_W + RECIP_SH;
	localparam logic [RECIP_W-1:0] RECIP_RE = RECIP_W'(((longint'(1) << RECIP_SH) +
		longint'(IMAGE_WIDTH - 2)) / longint'(IMAGE_WIDTH - 1));
	localparam logic [RECIP_W-1:0] RECIP_IM = RECIP_W'(((longint'(1) << RECIP_SH) +
		longint'(IMAGE_HEIGHT - 2)) / longint'(IMAGE_HEIGHT - 1));
	localparam int ITW = $clog2(MAX_ITER + 1);
	localparam logic [ITW-1:0] ITER_LIMIT = ITW'(MAX_ITER);
	localparam logic signed [47:0] SAT_HI = 48'sh0000_7FFF_FFFF;
	localparam logic signed [47:0] SAT_LO = 48'shFFFF_8000_0000;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [47:0] v);
		if (v > SAT_HI)
			return 32'sh7FFF_FFFF;
		if (v < SAT_LO)
			return 32'sh8000_0000;
		return v[Q_W-1:0];
	endfunction

	// view rectangle
	logic signed [Q_W-1:0] real_min_q, real_max_q, imag_min_q, imag_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_min_q <= REAL_MIN_RST;
			real_max_q <= REAL_MAX_RST;
			imag_min_q <= IMAG_MIN_RST;
			imag_max_q <= IMAG_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REAL_MIN: real_min_q <= cfg_data;
				REG_REAL_MAX: real_max_q <= cfg_data;
				REG_IMAG_MIN: imag_min_q <= cfg_data;
				REG_IMAG_MAX: imag_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [COORD_W-1:0] col_q, row_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= in_column;
			row_q <= in_row;
		end
	end

	// ---- mapping: coord*delta, then reciprocal multiply by 1/(size-1) ----
	logic [COORD_W-1:0]       map_coord;
	logic signed [Q_W-1:0]    map_lo, map_hi;
	logic signed [Q_W:0]      delta;
	logic signed [COORD_W:0]  coord_s;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]        prod_mag;

	assign map_coord = cmd.div_axis ? row_q : col_q;
	assign map_lo    = cmd.div_axis ? imag_min_q : real_min_q;
	assign map_hi    = cmd.div_axis ? imag_max_q : real_max_q;
	assign delta     = (Q_W+1)'(map_hi) - (Q_W+1)'(map_lo);
	assign coord_s   = $signed({1'b0, map_coord});
	assign prod      = coord_s * delta;
	assign prod_mag  = prod[PROD_W-1] ? PROD_W'(-prod) : prod;

	logic               div_neg_q, div_axis_q;
	logic [MAG_W-1:0]   dvd_q;
	logic [ACC_W-1:0]   acc_q;
	logic [1:0]         div_ph_q;   // bit 1: dividend half, bit 0: reciprocal half
	logic [RECIP_W-1:0] recip;
	logic [Q_W-1:0]     mac_a, mac_b;
	logic [2*Q_W-1:0]   mac_p;
	logic [ACC_W-1:0]   mac_add;

	assign recip = div_axis_q ? RECIP_IM : RECIP_RE;
	assign mac_a = div_ph_q[1] ? Q_W'(dvd_q[MAG_W-1:Q_W]) : dvd_q[Q_W-1:0];
	assign mac_b = div_ph_q[0] ? Q_W'(recip[RECIP_W-1:Q_W]) : recip[Q_W-1:0];
	assign mac_p = mac_a * mac_b;

	// high x high lands at bit 64; full product stays below 2^96
	always_comb begin
		case (div_ph_q)
			2'd0:    mac_add = ACC_W'(mac_p);
			2'd3:    mac_add = {mac_p[Q_W-1:0], {(2*Q_W){1'b0}}};
			default: mac_add = {mac_p, {Q_W{1'b0}}};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_neg_q  <= prod[PROD_W-1];
			div_axis_q <= cmd.div_axis;
			dvd_q      <= prod_mag[MAG_W-1:0];
			acc_q      <= '0;
			div_ph_q   <= '0;
		end else if (cmd.div_step) begin
			acc_q    <= acc_q + mac_add;
			div_ph_q <= div_ph_q + 1'b1;
		end
	end

	// signed quotient, truncated toward zero
	logic [MAG_W-1:0]         quo;
	logic signed [PROD_W-1:0] quo_s;
	logic signed [47:0]       c_re_sum, c_im_sum;

	assign quo      = acc_q[ACC_W-1:RECIP_SH];
	assign quo_s    = div_neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
	assign c_re_sum = 48'(real_min_q) + 48'(quo_s);
	assign c_im_sum = 48'(imag_min_q) + 48'(quo_s);

	logic signed [Q_W-1:0] cr_q, ci_q;

	always_ff @(posedge clk) begin
		if (cmd.c_store_re)
			cr_q <= sat_q(c_re_sum);
		if (cmd.c_store_im)
			ci_q <= sat_q(c_im_sum);
	end

	// ---- iteration ----
	logic signed [Q_W-1:0] zr_q, zi_q;
	logic signed [63:0]    rr_q, ii_q, ri_q;
	logic [ITW-1:0]        iter_q;
	logic signed [63:0]    diff;
	logic signed [35:0]    diff_sh;   // floor(diff / 2^28)
	logic signed [36:0]    ri_sh;     // floor(ri / 2^27)
	logic signed [47:0]    nr_sum, ni_sum;
	logic [63:0]           mag;

	assign diff    = rr_q - ii_q;
	assign diff_sh = diff[63:FRAC_W];
	assign ri_sh   = ri_q[63:FRAC_W-1];
	assign nr_sum  = 48'(diff_sh) + 48'(cr_q);
	assign ni_sum  = 48'(ri_sh) + 48'(ci_q);
	assign mag     = $unsigned(rr_q) + $unsigned(ii_q);

	assign sts.mag_over = (mag > ESC_LIMIT);
	assign sts.iter_max = (iter_q == ITER_LIMIT);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rr_q <= zr_q * zr_q;
			ii_q <= zi_q * zi_q;
			ri_q <= zr_q * zi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.z_clear) begin
			iter_q <= '0;
		end else if (cmd.update) begin
			iter_q <= iter_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.z_clear) begin
			zr_q <= '0;
			zi_q <= '0;
		end else if (cmd.update) begin
			zr_q <= sat_q(nr_sum);
			zi_q <= sat_q(ni_sum);
		end
	end

	// ---- result ----
	// an escape is seen one update late, so the count is one less
	logic [15:0] steps, blue_raw;
	logic [31:0] idx_full;

	assign steps    = sts.mag_over ? 16'(iter_q - 1'b1) : 16'(iter_q);
	assign blue_raw = BLUE_BASE + BLUE_STEP * steps;
	assign idx_full = 32'(row_q) * 32'(IMAGE_WIDTH) + 32'(col_q);

	logic [INDEX_W-1:0] pixel_index_q;
	logic [COUNT_W-1:0] escape_count_q;
	logic               in_set_q;
	logic [BLUE_W-1:0]  blue_value_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_index_q  <= idx_full[INDEX_W-1:0];
			escape_count_q <= (steps > CH_MAX) ? COUNT_W'(CH_MAX) : steps[COUNT_W-1:0];
			in_set_q       <= !sts.mag_over;
			if (!sts.mag_over)
				blue_value_q <= '0;
			else
				blue_value_q <= (blue_raw > CH_MAX) ? BLUE_W'(CH_MAX) : blue_raw[BLUE_W-1:0];
		end
	end

	assign pixel_index  = pixel_index_q;
	assign escape_count = escape_count_q;
	assign in_set       = in_set_q;
	assign blue_value   = blue_value_q;

endmodule

[design/mandelbrot_escape_time_pixel_core.sv]
// Escape-time pixel core: one coordinate word in, one result word out.
// The time from accept to result valid grows with the steps a pixel takes
// to escape and is longest for a pixel in the set.
// Throughput: one pixel at a time; a new word is taken the cycle after the
// result is registered, even while that result still waits at the output.
// arst_n clears control and loads the default view rectangle (-2..1, -1.5..1.5).
module mandelbrot_escape_time_pixel_core #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 640,
	parameter int MAX_ITER     = 255
) (
	input logic           clk,
	input logic           arst_n,
	met_pix_in_if.sink    pixel_in,
	met_pix_out_if.source pixel_out,
	met_cfg_if.sink       cfg
);
	import met_pkg::*;

	// Steps per pixel, in order:
	//   clear z, load divider with column*(real_max-real_min)
	//   multiply by the reciprocal of IMAGE_WIDTH-1, one 32x32
	//   partial product accumulated a cycle
	//   latch c real, load divider for the row
	//   same for IMAGE_HEIGHT-1
	//   per iteration: three 32x32 products registered, then
	//   escape test and z update on those products
	//   result into the output register, once the previous result is taken
	// The iteration loop (multiply then update) dominates the time per pixel.

	met_cmd_t cmd;
	met_sts_t sts;

	// config writes always taken; unknown indexes dropped in the datapath
	assign cfg.ready = 1'b1;

	met_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_in.valid),
		.in_ready  (pixel_in.ready),
		.out_valid (pixel_out.valid),
		.out_ready (pixel_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	met_dp #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT),
		.MAX_ITER     (MAX_ITER)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.in_column    (pixel_in.column),
		.in_row       (pixel_in.row),
		.pixel_index  (pixel_out.pixel_index),
		.escape_count (pixel_out.escape_count),
		.in_set       (pixel_out.in_set),
		.blue_value   (pixel_out.blue_value)
	);

endmodule

[dv/mandelbrot_escape_time_pixel_core_tb.sv]
module mandelbrot_escape_time_pixel_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import met_pkg::*;

	// Same geometry and iteration limit as the block's defaults
	localparam int IMG_W      = 640;
	localparam int IMG_H      = 640;
	localparam int ITER_LIMIT = 255;

	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_PIXELS   = 228;   // 1824 random words in total
	localparam int HOLD_CYCLES    = 3000;  // long receiver hold-off for the pressure phase
	localparam int DRAIN_CYCLES   = 700;   // above the worst pixel latency at this iteration limit
	localparam int WATCHDOG_LIMIT = 20000; // silence limit, several times the longest stall

	localparam longint Q_ONE = longint'(1) << FRAC_W;
	localparam longint Q_HI  = 64'sd2147483647;
	localparam longint Q_LO  = -64'sd2147483648;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} pix_coord_t;

	typedef struct packed {
		logic [INDEX_W-1:0] pixel_index;
		logic [COUNT_W-1:0] escape_count;
		logic               in_set;
		logic [BLUE_W-1:0]  blue_value;
	} pix_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	met_pix_in_if  pix_in ();
	met_pix_out_if pix_out ();
	met_cfg_if     cfg_bus ();

	mandelbrot_escape_time_pixel_core #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H),
		.MAX_ITER    (ITER_LIMIT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel_in (pix_in),
		.pixel_out(pix_out),
		.cfg      (cfg_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the view rectangle, updated when a register word is taken
	longint view_real_min = -longint'(2) * Q_ONE;
	longint view_real_max = Q_ONE;
	longint view_imag_min = -(Q_ONE + Q_ONE / 2);
	longint view_imag_max = Q_ONE + Q_ONE / 2;

	pix_coord_t  pending_pixels[$];   // words still to be offered
	pix_result_t expected_results[$]; // predictions for accepted words, oldest first

	int errors = 0;

	// Knobs set by the sequencer between phases, while the block is idle
	bit sender_steady   = 1'b0;
	bit receiver_steady = 1'b0;
	bit hold_req        = 1'b0;

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	function automatic longint sat_q(longint v);
		if (v > Q_HI)
			return Q_HI;
		if (v < Q_LO)
			return Q_LO;
		return v;
	endfunction

	// lo + coord*(hi-lo)/(size-1); longint division truncates toward zero
	function automatic longint map_to_plane(longint lo, longint hi, longint coord, longint size);
		longint prod;
		prod = coord * (hi - lo);
		return sat_q(lo + prod / (size - 1));
	endfunction

	function automatic pix_result_t predict_pixel(pix_coord_t p);
		pix_result_t res;
		longint      cr, ci, zr, zi, rr, ii, ri, zr_next;
		logic [63:0] mag;
		int          n, blue;
		cr = map_to_plane(view_real_min, view_real_max, longint'(p.column), IMG_W);
		ci = map_to_plane(view_imag_min, view_imag_max, longint'(p.row), IMG_H);
		zr = 0;
		zi = 0;
		for (n = 0; n < ITER_LIMIT; n++) begin
			rr = zr * zr;
			ii = zi * zi;
			ri = zr * zi;
			// >>> on a signed longint is floor division by a power of two
			zr_next = sat_q(((rr - ii) >>> FRAC_W) + cr);
			zi = sat_q((ri >>> (FRAC_W - 1)) + ci);
			zr = zr_next;
			mag = $unsigned(zr * zr) + $unsigned(zi * zi);
			// exactly 4.0 does not count as escaped
			if (mag > ESC_LIMIT)
				break;
		end
		res.pixel_index  = INDEX_W'(int'(p.row) * IMG_W + int'(p.column));
		res.escape_count = (n > 255) ? COUNT_W'(255) : COUNT_W'(n);
		res.in_set       = (n == ITER_LIMIT);
		blue = int'(BLUE_BASE) + int'(BLUE_STEP) * n;
		if (res.in_set)
			res.blue_value = '0;
		else
			res.blue_value = (blue > int'(CH_MAX)) ? BLUE_W'(CH_MAX) : BLUE_W'(blue);
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Driver: offers pending words in bursts with gaps; valid holds until taken
	// ---------------------------------------------------------------------

	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_in.valid  <= 1'b0;
			pix_in.column <= '0;
			pix_in.row    <= '0;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			if (pix_in.valid && pix_in.ready) begin
				// config is stable while pixels flow, so predict on accept
				expected_results = {expected_results, predict_pixel(pending_pixels[0])};
				void'(pending_pixels.pop_front());
			end
			if (!pix_in.valid || pix_in.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					pix_in.valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					pix_in.valid  <= 1'b1;
					pix_in.column <= pending_pixels[0].column;
					pix_in.row    <= pending_pixels[0].row;
					if (burst_left > 1) begin
						burst_left--;
					end else if (!sender_steady) begin
						burst_left = $urandom_range(1, 10);
						// mostly short gaps, now and then one that spans a whole pixel
						case ($urandom_range(0, 9))
							0, 1, 2: gap_left = 0;
							3:       gap_left = $urandom_range(50, 650);
							default: gap_left = $urandom_range(1, 8);
						endcase
					end
				end else begin
					pix_in.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks each result word against the oldest prediction,
	// and drives ready with its own stall pattern and an optional hold-off
	// ---------------------------------------------------------------------

	int          stall_left = 0;
	int          hold_left  = 0;
	int          stall_pick;
	pix_result_t want;

	task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out.ready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word: expected none, actual index %0d count %0d",
						$time, pix_out.pixel_index, pix_out.escape_count);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("pixel_index", want.pixel_index, pix_out.pixel_index);
					check_field("escape_count", want.escape_count, pix_out.escape_count);
					check_field("in_set", want.in_set, pix_out.in_set);
					check_field("blue_value", want.blue_value, pix_out.blue_value);
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_out.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pix_out.ready <= 1'b0;
			end else begin
				pix_out.ready <= 1'b1;
				if (!receiver_steady) begin
					stall_pick = $urandom_range(0, 63);
					if (stall_pick == 0)
						stall_left = $urandom_range(100, 700);
					else if (stall_pick < 12)
						stall_left = $urandom_range(1, 12);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: cycles with no word taken on any channel
	// ---------------------------------------------------------------------

	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
			    (cfg_bus.valid && cfg_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog: no word taken for %0d cycles", $time, quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------

	// One register word; the local view copy follows on acceptance
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			REG_REAL_MIN: view_real_min = longint'($signed(value));
			REG_REAL_MAX: view_real_max = longint'($signed(value));
			REG_IMAG_MIN: view_imag_min = longint'($signed(value));
			REG_IMAG_MAX: view_imag_max = longint'($signed(value));
			default: ; // unmapped index, ignored by the block
		endcase
	endtask

	task automatic set_view(logic [Q_W-1:0] rmin, logic [Q_W-1:0] rmax,
	                        logic [Q_W-1:0] imin, logic [Q_W-1:0] imax);
		write_reg(REG_REAL_MIN, rmin);
		write_reg(REG_REAL_MAX, rmax);
		write_reg(REG_IMAG_MIN, imin);
		write_reg(REG_IMAG_MAX, imax);
	endtask

	task automatic add_pixel(int col, int row);
		pix_coord_t p;
		p.column = COORD_W'(col);
		p.row    = COORD_W'(row);
		pending_pixels = {pending_pixels, p};
	endtask

	// Every word causes one result, so an empty prediction store means idle
	task automatic drain();
		while (pending_pixels.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Mostly inside the image, sometimes beyond it to reach all ten bits
	function automatic int rand_coord();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, (1 << COORD_W) - 1);
		return $urandom_range(0, IMG_W - 1);
	endfunction

	// Small window around a random point near the set
	task automatic zoom_view();
		longint cr, ci, half;
		cr   = longint'($urandom_range(0, 5 * (1 << 27))) - longint'(2) * Q_ONE;
		ci   = longint'($urandom_range(0, 5 * (1 << 27))) - (Q_ONE + Q_ONE / 4);
		half = longint'(1) << $urandom_range(18, 27);
		set_view(Q_W'(cr - half), Q_W'(cr + half), Q_W'(ci - half), Q_W'(ci + half));
	endtask

	initial begin
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data  = '0;
		pix_in.valid  = 1'b0;
		pix_in.column = '0;
		pix_in.row    = '0;
		pix_out.ready = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset view untouched: corners, the center of the set,
		// coordinates past the image edge (extrapolation, index wrap)
		add_pixel(0, 0);
		add_pixel(IMG_W - 1, IMG_H - 1);
		add_pixel(0, IMG_H - 1);
		add_pixel(IMG_W - 1, 0);
		add_pixel(427, 320);
		add_pixel(IMG_W, IMG_H);
		add_pixel(1023, 1023);
		add_pixel(320, 1023);
		add_pixel(1023, 0);
		drain();

		// Flat imaginary axis: c = -2 sits exactly on |z|^2 == 4 each step,
		// c = -1 is a period-two orbit; also a write to an unmapped index
		sender_steady = 1'b1;
		set_view(REAL_MIN_RST, REAL_MAX_RST, '0, '0);
		write_reg(CFG_IDX_W'($urandom_range(int'(REG_IMAG_MAX) + 1, (1 << CFG_IDX_W) - 1)),
			$urandom);
		add_pixel(0, 0);
		add_pixel(0, 500);
		add_pixel(213, 0);
		add_pixel(IMG_W - 1, 0);
		drain();

		// Full-range edges, imaginary reversed: mapping and z saturate
		sender_steady = 1'b0;
		set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		add_pixel(0, 0);
		add_pixel(1023, 1023);
		add_pixel(319, 320);
		add_pixel(IMG_W - 1, IMG_H - 1);
		add_pixel(1023, 0);
		drain();

		// All edges equal: constant c = 0
		set_view('0, '0, '0, '0);
		add_pixel(0, 0);
		add_pixel(1023, 1023);
		drain();

		// Random phases, one view per phase
		for (int k = 0; k < RANDOM_PHASES; k++) begin
			sender_steady   = (k == 0);
			receiver_steady = (k == 0);
			case (k)
				0:       set_view(REAL_MIN_RST, REAL_MAX_RST, IMAG_MIN_RST, IMAG_MAX_RST);
				1, 4:    zoom_view();
				3:       set_view(REAL_MAX_RST, REAL_MIN_RST, IMAG_MAX_RST, IMAG_MIN_RST);
				5:       set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
				default: set_view($urandom, $urandom, $urandom, $urandom);
			endcase
			// pressure: receiver holds off while words keep coming
			if (k == 1) begin
				@(negedge clk);
				hold_req = 1'b1;
			end
			for (int i = 0; i < PHASE_PIXELS; i++)
				add_pixel(rand_coord(), rand_coord());
			drain();
		end

		// Catch any stray word after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
